// File: sv/kpd_pkg.sv
// keypad scanner package: word types, state type, line codes and the key map
// no dependencies
`default_nettype none

package kpd_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 3;
  localparam int ROW_BITS = 4;
  localparam int MAP_ROWS = 4;
  localparam int MAP_COLS = 3;
  localparam int LINE_W   = 3;
  localparam int COL_W    = 2;
  localparam int CHAR_W   = 7;

  localparam logic             MODE_SCAN = 1'b0;
  localparam logic             MODE_TICK = 1'b1;
  localparam logic [LINE_W-1:0] LINE_NONE = LINE_W'(NUM_ROWS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(NUM_COLS - 1);

  typedef struct packed {
    logic                mode;
    logic [ROW_BITS-1:0] row_levels;
  } kpd_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  drive_column;
    logic              key_valid;
    logic [CHAR_W-1:0] key_char;
  } kpd_out_t;

  typedef struct packed {
    logic [COL_W-1:0]  active_column;
    logic [LINE_W-1:0] current_line;
    logic [LINE_W-1:0] previous_line;
    logic [LINE_W-1:0] latched_line;
  } kpd_state_t;

  // fixed map "123" "456" "789" "*0#", zero outside it
  function automatic logic [CHAR_W-1:0] key_lookup(input logic [LINE_W-1:0] row,
                                                   input logic [COL_W-1:0]  col);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (row < LINE_W'(MAP_ROWS) && col < COL_W'(MAP_COLS)) begin
      case ({row[1:0], col})
        {2'd0, 2'd0}: ch = CHAR_W'("1");
        {2'd0, 2'd1}: ch = CHAR_W'("2");
        {2'd0, 2'd2}: ch = CHAR_W'("3");
        {2'd1, 2'd0}: ch = CHAR_W'("4");
        {2'd1, 2'd1}: ch = CHAR_W'("5");
        {2'd1, 2'd2}: ch = CHAR_W'("6");
        {2'd2, 2'd0}: ch = CHAR_W'("7");
        {2'd2, 2'd1}: ch = CHAR_W'("8");
        {2'd2, 2'd2}: ch = CHAR_W'("9");
        {2'd3, 2'd0}: ch = CHAR_W'("*");
        {2'd3, 2'd1}: ch = CHAR_W'("0");
        {2'd3, 2'd2}: ch = CHAR_W'("#");
        default:      ch = '0;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/keypad_scan_debounce_top.sv
// keypad scanner top level: scanner state, result register, handshakes
// depends on kpd_pkg and kpd_core
//
//   port group | direction | word      | handshake
//   in_        | input     | kpd_in_t  | in_valid / in_stall
//   out_       | output    | kpd_out_t | out_valid / out_stall
//
// one word per cycle while in_stall is low; each accepted word gives one result word in the cycle after
// the scanner state and the result register update in the same edge that takes the word
// the only limit on rate is the single result register: a word is taken while it is
// empty or being read in that same edge
// synchronous active-low reset: column 0, all lines none, result register empty
// a stall on the output holds the result and stalls the input; no word is dropped
`default_nettype none

module keypad_scan_debounce_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kpd_pkg::kpd_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kpd_pkg::kpd_out_t      out_word
);
  import kpd_pkg::*;

  kpd_state_t st_r, st_nxt;
  kpd_out_t   res_r, res_nxt;
  logic       out_valid_r;
  logic       in_take;

  // input stalls only while a finished result waits to be taken
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  kpd_core u_core (
    .st      (st_r),
    .in_word (in_word),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // scanner state advances only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.active_column <= '0;
      st_r.current_line  <= LINE_NONE;
      st_r.previous_line <= LINE_NONE;
      st_r.latched_line  <= LINE_NONE;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // result register: loads on accept, empties when read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

  // a reported key always carries a character from the map
  a_key_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.key_valid |-> res_r.key_char != '0)
    else $error("key reported without a character");

  // column stays within the keypad
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active_column <= COL_LAST)
    else $error("active column out of range");

  // while a row is latched the column does not move
  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.latched_line != LINE_NONE |=> $stable(st_r.active_column))
    else $error("column moved while a key is latched");

  // a scan word never reports a key
  a_scan_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_word.mode == MODE_SCAN |=> !res_r.key_valid)
    else $error("key reported on a scan word");

endmodule

`default_nettype wire

// File: sv/kpd_core.sv
// keypad scanner next-state logic: row encode, column advance, debounce
// depends on kpd_pkg
`default_nettype none

module kpd_core (
  input  wire kpd_pkg::kpd_state_t st,
  input  wire kpd_pkg::kpd_in_t    in_word,
  output kpd_pkg::kpd_state_t      st_nxt,
  output kpd_pkg::kpd_out_t        res
);
  import kpd_pkg::*;

  logic [LINE_W-1:0] enc_line;
  logic              valid;
  logic [CHAR_W-1:0] ch;

  // lowest-numbered low row wins
  always_comb begin
    enc_line = LINE_NONE;
    for (int r = ROW_BITS - 1; r >= 0; r--) begin
      if (r < NUM_ROWS && !in_word.row_levels[r]) enc_line = LINE_W'(r);
    end
  end

  always_comb begin
    st_nxt = st;
    valid  = 1'b0;
    ch     = '0;
    if (in_word.mode == MODE_SCAN) begin
      st_nxt.current_line = enc_line;
      if (enc_line == LINE_NONE && st.latched_line == LINE_NONE) begin
        st_nxt.active_column = (st.active_column >= COL_LAST) ? '0
                                                               : st.active_column + 1'b1;
      end
    end else begin
      if (st.current_line == st.previous_line) begin
        if (st.current_line != LINE_NONE && st.latched_line == LINE_NONE) begin
          st_nxt.latched_line = st.current_line;
        end else if (st.current_line == LINE_NONE && st.latched_line != LINE_NONE) begin
          valid               = 1'b1;
          ch                  = key_lookup(st.latched_line, st.active_column);
          st_nxt.latched_line = LINE_NONE;
        end
      end
      st_nxt.previous_line = st.current_line;
    end
  end

  assign res.drive_column = st_nxt.active_column;
  assign res.key_valid    = valid;
  assign res.key_char     = ch;

endmodule

`default_nettype wire
